>>> rtl/heatsink_fan_hysteresis_controller_macros.svh
// Assertion macros shared by the fan controller checker.
`ifndef HEATSINK_FAN_HYSTERESIS_CONTROLLER_MACROS_SVH
`define HEATSINK_FAN_HYSTERESIS_CONTROLLER_MACROS_SVH

// Same-cycle implication, gated by reset.
`define HFHC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, gated by reset.
`define HFHC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/hfhc_pkg.sv
// Shared constants for the heatsink fan hysteresis controller.
package hfhc_pkg;

    // Widths
    localparam int TEMP_WIDTH_DEFAULT = 13;
    localparam int HYS_WIDTH          = 8;
    localparam int LEVEL_WIDTH        = 3;
    localparam int DRIVE_WIDTH        = 2;
    localparam int CFG_INDEX_WIDTH    = 3;

    // Fan levels
    localparam logic [LEVEL_WIDTH-1:0] LVL_OVER   = 3'd0;
    localparam logic [LEVEL_WIDTH-1:0] LVL_FORCED = 3'd1;
    localparam logic [LEVEL_WIDTH-1:0] LVL_FULL   = 3'd2;
    localparam logic [LEVEL_WIDTH-1:0] LVL_MEDIUM = 3'd3;
    localparam logic [LEVEL_WIDTH-1:0] LVL_LOW    = 3'd4;
    localparam logic [LEVEL_WIDTH-1:0] LVL_OFF    = 3'd5;
    localparam logic [LEVEL_WIDTH-1:0] LVL_NONE   = 3'd7;

    // Drive codes: 2.5 V, 2.1 V, 1.8 V
    localparam logic [DRIVE_WIDTH-1:0] DRIVE_HIGH   = 2'd0;
    localparam logic [DRIVE_WIDTH-1:0] DRIVE_MEDIUM = 2'd1;
    localparam logic [DRIVE_WIDTH-1:0] DRIVE_LOW    = 2'd2;

    // Register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_OVERTEMP = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_FULL     = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_MEDIUM   = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_LOW      = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_HYST     = 3'd4;

    // Reset values
    localparam int OVERTEMP_RESET = 1280;
    localparam int FULL_RESET     = 800;
    localparam int MEDIUM_RESET   = 640;
    localparam int LOW_RESET      = 480;
    localparam logic [HYS_WIDTH-1:0] HYST_RESET = 8'd32;

endpackage

>>> rtl/heatsink_fan_hysteresis_controller.sv
// Heatsink fan controller: temperature bands with hysteresis to fan level and drive.
//
// Input channel (in_valid/in_ready) carries one temperature sample in 1/16 degree C
// and the high-voltage-active flag. Output channel (out_valid/out_ready) returns
// one result per sample: fan enable, drive code, command strobe, fan level and
// overtemperature fault.
// From input transfer to result valid the sample sits in the
// input register while the band compare chain and level update feed the result register.
// Throughput is one sample per cycle unless the receiver stalls; the only loop is the
// last-level register, which is updated in the same cycle the result register loads.
// When the receiver stalls, the result register holds and the input register keeps
// taking one more sample; in_ready drops only when both stages are full.
// Thresholds and hysteresis are written via cfg_write_en/cfg_index/cfg_data, by the user
// only while the block is idle (not enforced here); writes to unknown indexes are dropped.
// Reset restores the default thresholds, empties both stages and clears the last
// level to "none", so the first result always issues a command.
module heatsink_fan_hysteresis_controller #(
    parameter int TEMP_WIDTH = hfhc_pkg::TEMP_WIDTH_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration write port
    input  logic                                 cfg_write_en,
    input  logic [hfhc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [TEMP_WIDTH-1:0]                cfg_data,
    // input channel
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [TEMP_WIDTH-1:0]         temperature,
    input  logic                                 high_voltage_active,
    // output channel
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 fan_enable,
    output logic [hfhc_pkg::DRIVE_WIDTH-1:0]     drive_code,
    output logic                                 command_issued,
    output logic [hfhc_pkg::LEVEL_WIDTH-1:0]     fan_level,
    output logic                                 overtemp_fault
);
    import hfhc_pkg::*;

    localparam int EXT_WIDTH = TEMP_WIDTH + 2;

    // Configuration registers
    logic signed [TEMP_WIDTH-1:0] over_thr_reg;
    logic signed [TEMP_WIDTH-1:0] full_thr_reg;
    logic signed [TEMP_WIDTH-1:0] med_thr_reg;
    logic signed [TEMP_WIDTH-1:0] low_thr_reg;
    logic [HYS_WIDTH-1:0]         hyst_reg;

    // Input stage
    logic                         s1_valid_reg;
    logic signed [TEMP_WIDTH-1:0] s1_temp_reg;
    logic                         s1_hv_reg;

    // Result stage and level state
    logic                   out_valid_reg;
    logic                   out_enable_reg;
    logic [DRIVE_WIDTH-1:0] out_drive_reg;
    logic                   out_cmd_reg;
    logic [LEVEL_WIDTH-1:0] out_level_reg;
    logic                   out_fault_reg;
    logic [LEVEL_WIDTH-1:0] last_level_reg;

    logic                   out_load;
    logic                   s1_load;
    logic [LEVEL_WIDTH-1:0] level_next;
    logic                   cmd_next;
    logic                   fault_next;
    logic                   enable_next;
    logic [DRIVE_WIDTH-1:0] drive_next;

    logic signed [EXT_WIDTH-1:0] t_ext;
    logic signed [EXT_WIDTH-1:0] hys_ext;
    logic signed [EXT_WIDTH-1:0] full_ext;
    logic signed [EXT_WIDTH-1:0] med_ext;
    logic signed [EXT_WIDTH-1:0] low_ext;
    logic signed [EXT_WIDTH-1:0] over_ext;
    logic ge_over;
    logic ge_full_h;
    logic ge_full;
    logic ge_med_h;
    logic ge_med;
    logic ge_low_h;
    logic ge_low;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            over_thr_reg <= TEMP_WIDTH'(OVERTEMP_RESET);
            full_thr_reg <= TEMP_WIDTH'(FULL_RESET);
            med_thr_reg  <= TEMP_WIDTH'(MEDIUM_RESET);
            low_thr_reg  <= TEMP_WIDTH'(LOW_RESET);
            hyst_reg     <= HYST_RESET;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                REG_OVERTEMP: over_thr_reg <= cfg_data;
                REG_FULL:     full_thr_reg <= cfg_data;
                REG_MEDIUM:   med_thr_reg  <= cfg_data;
                REG_LOW:      low_thr_reg  <= cfg_data;
                REG_HYST:     hyst_reg     <= cfg_data[HYS_WIDTH-1:0];
                default:      ;
            endcase
        end
    end

    // Pipeline handshake: result stage loads when empty or drained
    assign out_load = s1_valid_reg && (!out_valid_reg || out_ready);
    assign s1_load  = in_valid && in_ready;
    assign in_ready = !s1_valid_reg || out_load;

    // Hold the input sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_load)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (out_load)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_temp_reg <= temperature;
            s1_hv_reg   <= high_voltage_active;
        end
    end

    // Extend to full precision so threshold plus hysteresis never wraps
    assign t_ext    = EXT_WIDTH'(s1_temp_reg);
    assign hys_ext  = $signed({{(EXT_WIDTH-HYS_WIDTH){1'b0}}, hyst_reg});
    assign over_ext = EXT_WIDTH'(over_thr_reg);
    assign full_ext = EXT_WIDTH'(full_thr_reg);
    assign med_ext  = EXT_WIDTH'(med_thr_reg);
    assign low_ext  = EXT_WIDTH'(low_thr_reg);

    assign ge_over   = t_ext >= over_ext;
    assign ge_full_h = t_ext >= (full_ext + hys_ext);
    assign ge_full   = t_ext >= full_ext;
    assign ge_med_h  = t_ext >= (med_ext + hys_ext);
    assign ge_med    = t_ext >= med_ext;
    assign ge_low_h  = t_ext >= (low_ext + hys_ext);
    assign ge_low    = t_ext >= low_ext;

    // Pick the level by priority; in a hysteresis zone hold the band's own level or the one below
    always_comb
    begin
        level_next = last_level_reg;
        cmd_next   = 1'b0;
        fault_next = 1'b0;
        if (ge_over)
        begin
            fault_next = 1'b1;
            level_next = LVL_OVER;
            cmd_next   = last_level_reg != LVL_OVER;
        end
        else if (s1_hv_reg)
        begin
            level_next = LVL_FORCED;
            cmd_next   = last_level_reg != LVL_FORCED;
        end
        else if (ge_full_h)
        begin
            level_next = LVL_FULL;
            cmd_next   = last_level_reg != LVL_FULL;
        end
        else if (ge_full)
        begin
            if (last_level_reg != LVL_MEDIUM && last_level_reg != LVL_FULL)
            begin
                level_next = LVL_FULL;
                cmd_next   = 1'b1;
            end
        end
        else if (ge_med_h)
        begin
            level_next = LVL_MEDIUM;
            cmd_next   = last_level_reg != LVL_MEDIUM;
        end
        else if (ge_med)
        begin
            if (last_level_reg != LVL_LOW && last_level_reg != LVL_MEDIUM)
            begin
                level_next = LVL_MEDIUM;
                cmd_next   = 1'b1;
            end
        end
        else if (ge_low_h)
        begin
            level_next = LVL_LOW;
            cmd_next   = last_level_reg != LVL_LOW;
        end
        else if (ge_low)
        begin
            if (last_level_reg != LVL_OFF && last_level_reg != LVL_LOW)
            begin
                level_next = LVL_LOW;
                cmd_next   = 1'b1;
            end
        end
        else
        begin
            level_next = LVL_OFF;
            cmd_next   = last_level_reg != LVL_OFF;
        end
    end

    // Map level to enable and drive; drive is zero while off
    always_comb
    begin
        enable_next = 1'b1;
        drive_next  = DRIVE_HIGH;
        if (level_next == LVL_MEDIUM)
        begin
            drive_next = DRIVE_MEDIUM;
        end
        else if (level_next == LVL_LOW)
        begin
            drive_next = DRIVE_LOW;
        end
        else if (level_next >= LVL_OFF)
        begin
            enable_next = 1'b0;
        end
    end

    // Advance the level state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_level_reg <= LVL_NONE;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                last_level_reg <= level_next;
                out_valid_reg  <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_enable_reg <= enable_next;
            out_drive_reg  <= drive_next;
            out_cmd_reg    <= cmd_next;
            out_level_reg  <= level_next;
            out_fault_reg  <= fault_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign fan_enable     = out_enable_reg;
    assign drive_code     = out_drive_reg;
    assign command_issued = out_cmd_reg;
    assign fan_level      = out_level_reg;
    assign overtemp_fault = out_fault_reg;

endmodule

>>> rtl/hfhc_checker.sv
// Port-level checker for the fan controller, bound to the top level.
`include "heatsink_fan_hysteresis_controller_macros.svh"

module hfhc_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic                             fan_enable,
    input logic [hfhc_pkg::DRIVE_WIDTH-1:0] drive_code,
    input logic                             command_issued,
    input logic [hfhc_pkg::LEVEL_WIDTH-1:0] fan_level,
    input logic                             overtemp_fault
);
    import hfhc_pkg::*;

    // A stalled result holds
    `HFHC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(fan_level) && $stable(command_issued) && $stable(overtemp_fault), "stalled result changed")

    // Enable follows the level
    `HFHC_ASSERT_SAME(a_enable_level, clk, rst_n, out_valid, fan_enable == (fan_level != LVL_OFF), "fan enable disagrees with level")

    // Fault means overtemp level at full drive
    `HFHC_ASSERT_SAME(a_fault_level, clk, rst_n, out_valid && overtemp_fault, fan_level == LVL_OVER && fan_enable && drive_code == DRIVE_HIGH, "fault without overtemp level")

    // Drive code follows the level
    `HFHC_ASSERT_SAME(a_drive_level, clk, rst_n, out_valid, (drive_code == DRIVE_MEDIUM) == (fan_level == LVL_MEDIUM) && (drive_code == DRIVE_LOW) == (fan_level == LVL_LOW), "drive code disagrees with level")

endmodule

bind heatsink_fan_hysteresis_controller hfhc_checker u_hfhc_checker (.*);
